### src/buddy_allocator_top_defines.svh
// Assertion macros for the buddy allocator.
// Used by buddy_allocator_top; expects clk_i and rst_ni in scope.
`ifndef BUDDY_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_ALLOCATOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BAL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("buddy allocator assertion failed");
`define BAL_ASSERT_IMPL(lbl, ante, cons) `BAL_ASSERT(lbl, (ante) |-> (cons))
`else
`define BAL_ASSERT(lbl, prop)
`define BAL_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

### src/bal_pkg.sv
// Shared constants, codes and types of the buddy allocator.
// No dependencies.
`timescale 1ns / 1ps
package bal_pkg;
  localparam int MIN_LOG_BLOCK_DEF = 5;
  localparam int MAX_LOG_HEAP_DEF  = 14;
  localparam int REQ_W     = 16;
  localparam int OFF_W     = 14;
  localparam int HDR_W     = 5;
  localparam int ORD_OUT_W = 4;
  localparam int ORD_W     = 5;
  localparam int SIZE_W    = REQ_W + 1;
  localparam int WORD_W    = 32;
  localparam int WORD_LG   = 5;
  localparam logic [HDR_W-1:0] HDR_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic             too_large;
    logic [ORD_W-1:0] need;
  } need_t;
endpackage

### src/buddy_allocator_top.sv
// Buddy allocator top level: control sequencer, free-map and slot memories.
// Depends on bal_pkg, bal_order and buddy_allocator_top_defines.svh.
//
//  channel | direction | handshake                    | payload
//  in      | sink      | in_valid_i / in_stall_o      | opcode, request_bytes, release_offset
//  out     | source    | out_valid_o / out_stall_i    | status, data_offset, granted_order
//  cfg     | sink      | cfg_valid_i / cfg_ready_o    | header_bytes
//
// One request at a time. Allocate scans free-map words (up to ~41 at default size), then
// splits level by level down to the needed order; free merges upward level by level.
// Each free-map step is a read-modify-write through the registered-read free-map memory.
// After reset a clearing pass over the 2^(MAX_LOG_HEAP-MIN_LOG_BLOCK) slots (512 by default)
// sweeps both memories; no request is taken until it ends. A held result does not block
// the next request from being taken.
`timescale 1ns / 1ps
`include "buddy_allocator_top_defines.svh"
module buddy_allocator_top #(
  parameter int MIN_LOG_BLOCK = bal_pkg::MIN_LOG_BLOCK_DEF,
  parameter int MAX_LOG_HEAP  = bal_pkg::MAX_LOG_HEAP_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            opcode_i,
  input  logic [bal_pkg::REQ_W-1:0]       request_bytes_i,
  input  logic [bal_pkg::OFF_W-1:0]       release_offset_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [bal_pkg::OFF_W-1:0]       data_offset_o,
  output logic [bal_pkg::ORD_OUT_W-1:0]   granted_order_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bal_pkg::HDR_W-1:0]       cfg_header_bytes_i
);
  localparam int LEVELS   = MAX_LOG_HEAP - MIN_LOG_BLOCK;
  localparam int SLOTS    = 1 << LEVELS;
  localparam int NODES    = (2 << LEVELS) - 1;
  localparam int FM_WORDS = (NODES + bal_pkg::WORD_W - 1) / bal_pkg::WORD_W;
  localparam int FMA_W    = (FM_WORDS > 1) ? $clog2(FM_WORDS) : 1;
  localparam int SA_W     = (LEVELS > 0) ? LEVELS : 1;
  localparam int CNT_W    = SA_W + 1;
  localparam int AW       = ((MAX_LOG_HEAP > bal_pkg::OFF_W) ? MAX_LOG_HEAP : bal_pkg::OFF_W) + 1;
  localparam int NW       = LEVELS + 6;
  localparam int ORD_W    = bal_pkg::ORD_W;
  localparam int WORD_W   = bal_pkg::WORD_W;
  localparam int WORD_LG  = bal_pkg::WORD_LG;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NEED, S_FCHK, S_FSLOT, S_MRD, S_MCHK,
    S_SRD, S_SCHK, S_SPLIT, S_SETRD, S_SET, S_RESP
  } state_e;

  // tree node index of the block of order ord at heap offset off
  function automatic logic [NW-1:0] node_of(input logic [ORD_W-1:0] ord,
                                            input logic [AW-1:0] off);
    logic [NW-1:0] base;
    logic [AW-1:0] sh;
    begin
      base = NW'((32'd1 << (MAX_LOG_HEAP - int'(ord))) - 32'd1);
      sh   = off >> ord;
      return base + NW'(sh);
    end
  endfunction

  state_e                     state_q;
  logic                       is_alloc_q;
  logic [CNT_W-1:0]           clr_q;
  logic [bal_pkg::HDR_W-1:0]  hdr_q;
  logic [bal_pkg::OFF_W-1:0]  rel_q;
  logic [AW-1:0]              off_q;
  logic [ORD_W-1:0]           ord_q;
  logic [ORD_W-1:0]           need_ord_q;
  logic [NW-1:0]              first_q;
  logic [FMA_W-1:0]           word_q;
  logic [NW-1:0]              set_node_q;
  logic [NW-1:0]              chk_node_q;
  bal_pkg::status_e           res_status_q;
  logic [bal_pkg::OFF_W-1:0]  res_off_q;
  logic [ORD_W-1:0]           res_ord_q;
  logic                       out_valid_q;
  bal_pkg::status_e           out_status_q;
  logic [bal_pkg::OFF_W-1:0]  out_off_q;
  logic [ORD_W-1:0]           out_ord_q;

  bal_pkg::need_t             need;
  logic                       in_take;

  // free map: one bit per tree node, packed into words
  logic [WORD_W-1:0] fmap_mem [FM_WORDS];
  logic              fm_we, fm_re;
  logic [FMA_W-1:0]  fm_waddr, fm_raddr;
  logic [WORD_W-1:0] fm_wdata, fm_rdata_q;
  // slot memory: {allocated mark, block order} per smallest-block slot
  logic [ORD_W:0]    slot_mem [SLOTS];
  logic              sl_we, sl_re;
  logic [SA_W-1:0]   sl_waddr, sl_raddr;
  logic [ORD_W:0]    sl_wdata, sl_rdata_q;

  logic [AW-1:0]        rel_ext, hdr_ext, foff;
  logic                 fbad;
  logic [NW-1:0]        last_node, wbase, idx, hit_node, blk, buddy_node, ord_node;
  logic [FMA_W-1:0]     last_word;
  logic [WORD_W-1:0]    masked;
  logic [WORD_LG-1:0]   pos;
  logic                 found;
  logic [AW-1:0]        ord_bit, alloc_off;
  logic [ORD_W-1:0]     stored_ord, clamp_ord;
  logic [ORD_W-1:0]     ord_dn;

  assign in_take     = in_valid_i && !in_stall_o;
  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  bal_order #(
    .MIN_LOG_BLOCK(MIN_LOG_BLOCK),
    .MAX_LOG_HEAP (MAX_LOG_HEAP)
  ) u_order (
    .clk_i          (clk_i),
    .en_i           (in_take),
    .request_bytes_i(request_bytes_i),
    .header_bytes_i (hdr_q),
    .need_o         (need)
  );

  always_comb begin
    rel_ext   = AW'(rel_q);
    hdr_ext   = AW'(hdr_q);
    foff      = rel_ext - hdr_ext;
    fbad      = (rel_ext < hdr_ext) ||
                ((foff & AW'((1 << MIN_LOG_BLOCK) - 1)) != '0) ||
                ((foff >> MAX_LOG_HEAP) != '0);
    ord_bit   = AW'(1) << ord_q;
    ord_dn    = ord_q - 1'b1;
    last_node = first_q << 1;
    last_word = last_node[WORD_LG +: FMA_W];
    wbase     = NW'(word_q) << WORD_LG;
    for (int j = 0; j < WORD_W; j++) begin
      idx       = wbase + NW'(j);
      masked[j] = fm_rdata_q[j] && (idx >= first_q) && (idx <= last_node);
    end
    pos   = '0;
    found = |masked;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (masked[j]) pos = WORD_LG'(j);
    end
    hit_node   = wbase + NW'(pos);
    blk        = hit_node - first_q;
    alloc_off  = AW'(blk) << ord_q;
    buddy_node = node_of(ord_q, off_q ^ ord_bit);
    ord_node   = node_of(ord_q, off_q);
    stored_ord = sl_rdata_q[ORD_W-1:0];
    if (stored_ord < ORD_W'(MIN_LOG_BLOCK)) clamp_ord = ORD_W'(MIN_LOG_BLOCK);
    else if (stored_ord > ORD_W'(MAX_LOG_HEAP)) clamp_ord = ORD_W'(MAX_LOG_HEAP);
    else clamp_ord = stored_ord;

    fm_we    = 1'b0;
    fm_re    = 1'b0;
    fm_waddr = '0;
    fm_raddr = '0;
    fm_wdata = '0;
    sl_we    = 1'b0;
    sl_re    = 1'b0;
    sl_waddr = off_q[MIN_LOG_BLOCK +: SA_W];
    sl_raddr = foff[MIN_LOG_BLOCK +: SA_W];
    sl_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        sl_we    = 1'b1;
        sl_waddr = SA_W'(clr_q);
        fm_we    = clr_q < CNT_W'(FM_WORDS);
        fm_waddr = FMA_W'(clr_q);
        fm_wdata = (clr_q == '0) ? WORD_W'(1) : '0;
      end
      S_FCHK: sl_re = !fbad;
      S_FSLOT: begin
        sl_we    = sl_rdata_q[ORD_W];
        sl_wdata = {1'b0, stored_ord};
      end
      S_MRD: begin
        fm_re    = ord_q != ORD_W'(MAX_LOG_HEAP);
        fm_raddr = buddy_node[WORD_LG +: FMA_W];
      end
      S_MCHK: begin
        fm_we    = fm_rdata_q[chk_node_q[WORD_LG-1:0]];
        fm_waddr = chk_node_q[WORD_LG +: FMA_W];
        fm_wdata = fm_rdata_q & ~(WORD_W'(1) << chk_node_q[WORD_LG-1:0]);
      end
      S_SRD: begin
        fm_re    = 1'b1;
        fm_raddr = word_q;
      end
      S_SCHK: begin
        fm_we    = found;
        fm_waddr = word_q;
        fm_wdata = fm_rdata_q & ~(WORD_W'(1) << pos);
      end
      S_SPLIT: begin
        sl_we    = ord_q == need_ord_q;
        sl_wdata = {1'b1, need_ord_q};
      end
      S_SETRD: begin
        fm_re    = 1'b1;
        fm_raddr = set_node_q[WORD_LG +: FMA_W];
      end
      S_SET: begin
        fm_we    = 1'b1;
        fm_waddr = set_node_q[WORD_LG +: FMA_W];
        fm_wdata = fm_rdata_q | (WORD_W'(1) << set_node_q[WORD_LG-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (fm_we) fmap_mem[fm_waddr] <= fm_wdata;
    if (fm_re) fm_rdata_q <= fmap_mem[fm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) slot_mem[sl_waddr] <= sl_wdata;
    if (sl_re) sl_rdata_q <= slot_mem[sl_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      hdr_q        <= bal_pkg::HDR_RESET;
      out_valid_q  <= 1'b0;
      is_alloc_q   <= 1'b0;
      rel_q        <= '0;
      off_q        <= '0;
      ord_q        <= '0;
      need_ord_q   <= '0;
      first_q      <= '0;
      word_q       <= '0;
      set_node_q   <= '0;
      chk_node_q   <= '0;
      res_status_q <= bal_pkg::ST_DONE;
      res_off_q    <= '0;
      res_ord_q    <= '0;
      out_status_q <= bal_pkg::ST_DONE;
      out_off_q    <= '0;
      out_ord_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) hdr_q <= cfg_header_bytes_i;
      // drop the result once taken; the response state reloads it itself
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CNT_W'(SLOTS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_take) begin
            is_alloc_q <= opcode_i == bal_pkg::OP_ALLOC;
            rel_q      <= release_offset_i;
            state_q    <= (opcode_i == bal_pkg::OP_ALLOC) ? S_NEED : S_FCHK;
          end
        end
        S_NEED: begin
          if (need.too_large) begin
            res_status_q <= bal_pkg::ST_NO_SPACE;
            res_off_q    <= '0;
            res_ord_q    <= '0;
            state_q      <= S_RESP;
          end else begin
            ord_q      <= need.need;
            need_ord_q <= need.need;
            first_q    <= node_of(need.need, '0);
            word_q     <= FMA_W'(node_of(need.need, '0) >> WORD_LG);
            state_q    <= S_SRD;
          end
        end
        S_SRD: state_q <= S_SCHK;
        S_SCHK: begin
          if (found) begin
            off_q   <= alloc_off;
            state_q <= S_SPLIT;
          end else if (word_q == last_word) begin
            if (ord_q == ORD_W'(MAX_LOG_HEAP)) begin
              res_status_q <= bal_pkg::ST_NO_SPACE;
              res_off_q    <= '0;
              res_ord_q    <= '0;
              state_q      <= S_RESP;
            end else begin
              // advance to the next larger order
              ord_q   <= ord_q + 1'b1;
              first_q <= node_of(ord_q + 1'b1, '0);
              word_q  <= FMA_W'(node_of(ord_q + 1'b1, '0) >> WORD_LG);
              state_q <= S_SRD;
            end
          end else begin
            word_q  <= word_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_SPLIT: begin
          if (ord_q == need_ord_q) begin
            res_status_q <= bal_pkg::ST_DONE;
            res_off_q    <= bal_pkg::OFF_W'(off_q + hdr_ext);
            res_ord_q    <= need_ord_q;
            state_q      <= S_RESP;
          end else begin
            // keep the lower half, free the upper half
            ord_q      <= ord_dn;
            set_node_q <= node_of(ord_dn, off_q | (AW'(1) << ord_dn));
            state_q    <= S_SETRD;
          end
        end
        S_SETRD: state_q <= S_SET;
        S_SET: begin
          if (is_alloc_q) begin
            state_q <= S_SPLIT;
          end else begin
            res_status_q <= bal_pkg::ST_DONE;
            res_off_q    <= '0;
            res_ord_q    <= ord_q;
            state_q      <= S_RESP;
          end
        end
        S_FCHK: begin
          off_q <= foff;
          if (fbad) begin
            res_status_q <= bal_pkg::ST_BAD_FREE;
            res_off_q    <= '0;
            res_ord_q    <= '0;
            state_q      <= S_RESP;
          end else begin
            state_q <= S_FSLOT;
          end
        end
        S_FSLOT: begin
          if (!sl_rdata_q[ORD_W]) begin
            res_status_q <= bal_pkg::ST_BAD_FREE;
            res_off_q    <= '0;
            res_ord_q    <= '0;
            state_q      <= S_RESP;
          end else begin
            ord_q   <= clamp_ord;
            state_q <= S_MRD;
          end
        end
        S_MRD: begin
          if (ord_q == ORD_W'(MAX_LOG_HEAP)) begin
            set_node_q <= ord_node;
            state_q    <= S_SETRD;
          end else begin
            chk_node_q <= buddy_node;
            state_q    <= S_MCHK;
          end
        end
        S_MCHK: begin
          if (fm_rdata_q[chk_node_q[WORD_LG-1:0]]) begin
            // buddy free: merge upward
            off_q   <= off_q & ~ord_bit;
            ord_q   <= ord_q + 1'b1;
            state_q <= S_MRD;
          end else begin
            set_node_q <= ord_node;
            state_q    <= S_SETRD;
          end
        end
        S_RESP: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_off_q    <= res_off_q;
            out_ord_q    <= res_ord_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign data_offset_o   = out_off_q;
  assign granted_order_o = bal_pkg::ORD_OUT_W'(out_ord_q);

  `BAL_ASSERT_IMPL(a_err_zero, out_valid_q && (out_status_q != bal_pkg::ST_DONE), (out_off_q == '0) && (out_ord_q == '0))
  `BAL_ASSERT(a_busy_after_take, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `BAL_ASSERT(a_hold_result, ((state_q == S_RESP) && out_valid_q && out_stall_i) |=> (state_q == S_RESP))
  `BAL_ASSERT_IMPL(a_no_take_in_clear, state_q == S_CLEAR, !fm_re && !sl_re)
endmodule

### src/bal_order.sv
// Rounds request plus header up to a block order, registered.
// Depends on bal_pkg.
`timescale 1ns / 1ps
module bal_order #(
  parameter int MIN_LOG_BLOCK = bal_pkg::MIN_LOG_BLOCK_DEF,
  parameter int MAX_LOG_HEAP  = bal_pkg::MAX_LOG_HEAP_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [bal_pkg::REQ_W-1:0]   request_bytes_i,
  input  logic [bal_pkg::HDR_W-1:0]   header_bytes_i,
  output bal_pkg::need_t              need_o
);
  logic [bal_pkg::SIZE_W-1:0] size;
  logic [bal_pkg::SIZE_W-1:0] size_m1;
  logic [bal_pkg::ORD_W-1:0]  len;
  bal_pkg::need_t             need_d;
  bal_pkg::need_t             need_q;

  always_comb begin
    size    = bal_pkg::SIZE_W'(request_bytes_i) + bal_pkg::SIZE_W'(header_bytes_i);
    size_m1 = (size == '0) ? '0 : size - 1'b1;
    len     = '0;
    // bit length of size-1 is the smallest order that holds size
    for (int j = 0; j < bal_pkg::SIZE_W; j++) begin
      if (size_m1[j]) len = bal_pkg::ORD_W'(j + 1);
    end
    need_d.too_large = len > bal_pkg::ORD_W'(MAX_LOG_HEAP);
    need_d.need = (len < bal_pkg::ORD_W'(MIN_LOG_BLOCK)) ?
                  bal_pkg::ORD_W'(MIN_LOG_BLOCK) : len;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) need_q <= need_d;
  end

  assign need_o = need_q;
endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for buddy_allocator_top: random and directed requests,
// a tracking allocator model, and result checks. Depends on bal_pkg and the RTL.
`timescale 1ns / 1ps
module tb_top;
  localparam int MINB  = bal_pkg::MIN_LOG_BLOCK_DEF;
  localparam int MAXH  = bal_pkg::MAX_LOG_HEAP_DEF;
  localparam int SLOTS = 1 << (MAXH - MINB);
  localparam int NODES = (2 << (MAXH - MINB)) - 1;
  localparam int LIMIT = 2000000;

  typedef struct {
    bal_pkg::opcode_e                 op;
    logic [bal_pkg::REQ_W-1:0]        req_bytes;
    logic [bal_pkg::OFF_W-1:0]        rel_off;
  } request_t;

  typedef struct {
    bal_pkg::status_e                 status;
    logic [bal_pkg::OFF_W-1:0]        data_off;
    logic [bal_pkg::ORD_OUT_W-1:0]    order;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_stall = 1'b0, cfg_valid = 1'b0;
  logic opcode = 1'b0;
  logic [bal_pkg::REQ_W-1:0] req_bytes = '0;
  logic [bal_pkg::OFF_W-1:0] rel_off = '0;
  logic [bal_pkg::HDR_W-1:0] cfg_hdr = '0;
  logic in_stall, out_valid, cfg_ready;
  logic [1:0] status;
  logic [bal_pkg::OFF_W-1:0] data_off;
  logic [bal_pkg::ORD_OUT_W-1:0] order;

  buddy_allocator_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .request_bytes_i(req_bytes), .release_offset_i(rel_off),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .data_offset_o(data_off), .granted_order_o(order),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_header_bytes_i(cfg_hdr)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // allocator state as predicted
  bit          heap_free[NODES];
  bit          slot_used[SLOTS];
  int unsigned slot_order[SLOTS];
  int unsigned hdr;
  int unsigned live_offs[$];   // data offsets of live blocks, for well-formed frees

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int  errors = 0;
  int  cycles = 0;
  int  in_gap = 0, out_gap = 0;

  function automatic int unsigned node_idx(int unsigned ord, int unsigned off);
    return ((1 << (MAXH - ord)) - 1) + (off >> ord);
  endfunction

  function automatic grant_t predict_grant(request_t r);
    grant_t g;
    int unsigned need, sz, off, slot, ord, bud, t;
    bit found;
    g.status = bal_pkg::ST_DONE; g.data_off = '0; g.order = '0;
    if (r.op == bal_pkg::OP_ALLOC) begin
      sz = r.req_bytes + hdr;
      need = MINB;
      while (need <= MAXH && (1 << need) < sz) need++;
      found = 1'b0;
      if (need <= MAXH) begin
        for (t = need; t <= MAXH && !found; t++) begin
          for (int b = 0; b < (1 << (MAXH - t)) && !found; b++) begin
            off = b << t;
            if (heap_free[node_idx(t, off)]) begin
              found = 1'b1;
              heap_free[node_idx(t, off)] = 1'b0;
              ord = t;
              while (ord > need) begin
                ord--;
                heap_free[node_idx(ord, off + (1 << ord))] = 1'b1;
              end
              slot_used[off >> MINB] = 1'b1;
              slot_order[off >> MINB] = need;
              g.data_off = bal_pkg::OFF_W'(off + hdr);
              g.order = bal_pkg::ORD_OUT_W'(need);
              live_offs.push_back(off + hdr);
            end
          end
        end
      end
      if (!found) g.status = bal_pkg::ST_NO_SPACE;
    end else begin
      off = r.rel_off - hdr;
      slot = off >> MINB;
      if (r.rel_off < hdr || off[MINB-1:0] != 0 || slot >= SLOTS || !slot_used[slot]) begin
        g.status = bal_pkg::ST_BAD_FREE;
      end else begin
        ord = slot_order[slot];
        slot_used[slot] = 1'b0;
        while (ord < MAXH) begin
          bud = off ^ (1 << ord);
          if (!heap_free[node_idx(ord, bud)]) break;
          heap_free[node_idx(ord, bud)] = 1'b0;
          off &= ~(1 << ord);
          ord++;
        end
        heap_free[node_idx(ord, off)] = 1'b1;
        g.order = bal_pkg::ORD_OUT_W'(ord);
      end
    end
    return g;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_grants.push_back(predict_grant(pending_reqs.pop_front()));
        in_gap = pick_gap();
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (pending_reqs.size() > 0 && in_gap == 0) begin
        in_valid  <= 1'b1;
        opcode    <= pending_reqs[0].op;
        req_bytes <= pending_reqs[0].req_bytes;
        rel_off   <= pending_reqs[0].rel_off;
      end else begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    grant_t e;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result status=%0d off=%0d ord=%0d",
                 $time, status, data_off, order);
        errors++;
      end else begin
        e = expected_grants.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, status);
          errors++;
        end
        if (data_off !== e.data_off) begin
          $display("%0t: data_offset expected %0d actual %0d", $time, e.data_off, data_off);
          errors++;
        end
        if (order !== e.order) begin
          $display("%0t: granted_order expected %0d actual %0d", $time, e.order, order);
          errors++;
        end
      end
    end
    if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else begin
      out_stall <= 1'b0;
      out_gap = pick_gap();
    end
    if (cycles > LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic push_req(bal_pkg::opcode_e op, int unsigned nbytes, int unsigned roff);
    request_t r;
    r.op = op;
    r.req_bytes = bal_pkg::REQ_W'(nbytes);
    r.rel_off = bal_pkg::OFF_W'(roff);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_grants.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // predictions run at acceptance; sync so live_offs reflects issued allocates
  task automatic wait_idle_short();
    while (pending_reqs.size() > 0 || in_valid) @(posedge clk);
  endtask

  task automatic write_header(int unsigned value);
    cfg_valid <= 1'b1;
    cfg_hdr   <= bal_pkg::HDR_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    hdr = value;
  endtask

  // mostly allocate/free sequences that free live blocks, plus some noise
  task automatic random_phase(int n);
    int unsigned p, k;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        k = $urandom_range(0, 99);
        if (k < 70)      push_req(bal_pkg::OP_ALLOC, $urandom_range(0, 200), $urandom);
        else if (k < 93) push_req(bal_pkg::OP_ALLOC, $urandom_range(0, 4096), $urandom);
        else             push_req(bal_pkg::OP_ALLOC, $urandom, $urandom);
      end else if (p < 85 && live_offs.size() > 0) begin
        wait_idle_short();
        k = $urandom_range(0, live_offs.size() - 1);
        push_req(bal_pkg::OP_FREE, $urandom, live_offs[k]);
        live_offs.delete(k);
      end else begin
        push_req(bal_pkg::OP_FREE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    hdr = bal_pkg::HDR_RESET;
    heap_free[0] = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, exhaustion, bad frees, full merge
    push_req(bal_pkg::OP_ALLOC, 0, 0);
    push_req(bal_pkg::OP_ALLOC, 16'hFFFF, 0);
    push_req(bal_pkg::OP_ALLOC, (1 << MAXH) - bal_pkg::HDR_RESET + 1, 0);
    push_req(bal_pkg::OP_ALLOC, 100, 0);
    push_req(bal_pkg::OP_ALLOC, 8000, 0);
    push_req(bal_pkg::OP_ALLOC, 8000, 0);
    push_req(bal_pkg::OP_FREE, 0, 3);
    push_req(bal_pkg::OP_FREE, 16'hFFFF, 14'h3FFF);
    push_req(bal_pkg::OP_FREE, 0, bal_pkg::HDR_RESET + 1);
    push_req(bal_pkg::OP_FREE, 0, bal_pkg::HDR_RESET + 512);
    wait_idle();
    while (live_offs.size() > 0) begin
      push_req(bal_pkg::OP_FREE, 0, live_offs.pop_front());
      wait_idle_short();
    end
    push_req(bal_pkg::OP_ALLOC, (1 << MAXH) - bal_pkg::HDR_RESET, 0);
    wait_idle();
    push_req(bal_pkg::OP_FREE, 0, live_offs.pop_front());
    wait_idle();

    write_header(0);
    push_req(bal_pkg::OP_ALLOC, 1 << MAXH, 0);
    push_req(bal_pkg::OP_ALLOC, 0, 0);
    random_phase(150);
    wait_idle();
    write_header(31);
    // stale offsets from the old header now probe frees under the changed header
    random_phase(200);
    wait_idle();
    write_header($urandom_range(1, 30));
    random_phase(150);
    wait_idle();
    write_header(16);
    random_phase(130);
    wait_idle();

    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end
endmodule
